/* sv/tasp_pkg.sv */
`timescale 1ns / 1ps

package tasp_pkg;

  // Default sizing
  localparam int TASP_COUNT_WIDTH   = 24;
  localparam int TASP_POS_WIDTH     = 24;
  localparam int TASP_HOME_POSITION = 100000;

  // Fixed field widths
  localparam int OPCODE_W = 2;
  localparam int AXIS_W   = 2;
  localparam int NUM_AXES = 3;
  localparam int STOP_W   = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_RESET = 2'd2
  } opcode_t;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_sel_t;

  // Per-axis command for the transaction being applied this cycle
  typedef struct packed {
    logic tick;
    logic load;
    logic clear;
  } axis_ctrl_t;

  // Per-axis pin and status values after the transaction
  typedef struct packed {
    logic step_level;
    logic dir_pin;
    logic active;
    logic stepped;
  } axis_stat_t;

endpackage

/* sv/three_axis_step_pulse_generator.sv */
`timescale 1ns / 1ps

// Three-axis step/direction pulse generator.
// Input channel (in_*): one transaction per item: tick, load move for one
// axis, or reset of all motion state. End stop levels are sampled on ticks.
// Result channel (out_*): exactly one result per input transaction, carrying
// step and direction pin levels, positions, active axes, the step-taken flag
// and the end stop flags as they stand after that item.
// An accepted item is held in the input register, then its result is
// registered in the result register once the result slot is free, and is
// held there until out_ready takes it.
// Throughput: one item per cycle while the receiver takes results; each axis
// updates its counters once per item through one pass of per-axis logic
// between the input register and the result register.
// Reset (rst_n low, synchronous): all axes idle, pins low, positions at
// HOME_POSITION, both channels empty.
// When the receiver stalls, the result is held and the pending input item
// waits in the input register; in_ready drops only while both are full.
module three_axis_step_pulse_generator import tasp_pkg::*; #(
  parameter int COUNT_WIDTH   = TASP_COUNT_WIDTH,
  parameter int POS_WIDTH     = TASP_POS_WIDTH,
  parameter int HOME_POSITION = TASP_HOME_POSITION
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [OPCODE_W-1:0]         in_opcode,
  input  logic [AXIS_W-1:0]           in_axis,
  input  logic [COUNT_WIDTH-1:0]      in_step_count,
  input  logic [COUNT_WIDTH-1:0]      in_period,
  input  logic                        in_direction,
  input  logic                        in_stop_left,
  input  logic                        in_stop_right,
  input  logic                        in_stop_far,
  input  logic                        in_stop_close,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_step_x,
  output logic                        out_step_y,
  output logic                        out_step_z,
  output logic                        out_dir_x,
  output logic                        out_dir_y,
  output logic                        out_dir_z,
  output logic signed [POS_WIDTH-1:0] out_pos_x,
  output logic signed [POS_WIDTH-1:0] out_pos_y,
  output logic signed [POS_WIDTH-1:0] out_pos_z,
  output logic [NUM_AXES-1:0]         out_active_axes,
  output logic                        out_step_taken,
  output logic [STOP_W-1:0]           out_stop_flags
);

  // Input register
  logic                   in_full_r;
  logic [OPCODE_W-1:0]    opcode_r;
  logic [AXIS_W-1:0]      axis_r;
  logic [COUNT_WIDTH-1:0] step_count_r;
  logic [COUNT_WIDTH-1:0] period_r;
  logic                   direction_r;
  logic [STOP_W-1:0]      stops_r;

  logic                   advance;
  logic                   in_fire;
  logic                   is_tick, is_load, is_clear;
  logic [STOP_W-1:0]      stop_status_r, stop_status_nxt;

  axis_ctrl_t             ctrl_x, ctrl_y, ctrl_z;
  axis_stat_t             stat_x, stat_y, stat_z;
  logic signed [POS_WIDTH-1:0] pos_x_nxt, pos_y_nxt, pos_z_nxt;

  // Result register
  logic                   out_valid_r;
  axis_stat_t             res_x_r, res_y_r, res_z_r;
  logic signed [POS_WIDTH-1:0] res_pos_x_r, res_pos_y_r, res_pos_z_r;
  logic                   res_taken_r;
  logic [STOP_W-1:0]      res_stops_r;

  // Handshake: process the held item whenever the result slot is free
  assign advance  = in_full_r && (!out_valid_r || out_ready);
  assign in_ready = !in_full_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_fire) begin
      in_full_r <= 1'b1;
    end else if (advance) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      opcode_r     <= in_opcode;
      axis_r       <= in_axis;
      step_count_r <= in_step_count;
      period_r     <= in_period;
      direction_r  <= in_direction;
      stops_r      <= {in_stop_close, in_stop_far, in_stop_right, in_stop_left};
    end
  end

  // Opcode decode
  always_comb begin
    is_tick  = 1'b0;
    is_load  = 1'b0;
    is_clear = 1'b0;
    unique case (opcode_r)
      OP_TICK:  is_tick  = advance;
      OP_LOAD:  is_load  = advance;
      OP_RESET: is_clear = advance;
      default:  ;
    endcase
  end

  // Per-axis commands; a load to an unknown axis reaches none
  always_comb begin
    ctrl_x = '{tick: is_tick, load: 1'b0, clear: is_clear};
    ctrl_y = '{tick: is_tick, load: 1'b0, clear: is_clear};
    ctrl_z = '{tick: is_tick, load: 1'b0, clear: is_clear};
    unique case (axis_r)
      AXIS_X:  ctrl_x.load = is_load;
      AXIS_Y:  ctrl_y.load = is_load;
      AXIS_Z:  ctrl_z.load = is_load;
      default: ;
    endcase
  end

  // End stop flags
  always_comb begin
    stop_status_nxt = stop_status_r;
    if (is_clear) begin
      stop_status_nxt = '0;
    end else if (is_tick) begin
      stop_status_nxt = stops_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_status_r <= '0;
    end else begin
      stop_status_r <= stop_status_nxt;
    end
  end

  tasp_axis #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .POS_WIDTH    (POS_WIDTH),
    .HOME_POSITION(HOME_POSITION)
  ) u_axis_x (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl_x),
    .stop_neg   (stops_r[0]),
    .stop_pos   (stops_r[1]),
    .load_count (step_count_r),
    .load_period(period_r),
    .load_dir   (direction_r),
    .stat_nxt   (stat_x),
    .pos_nxt    (pos_x_nxt)
  );

  tasp_axis #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .POS_WIDTH    (POS_WIDTH),
    .HOME_POSITION(HOME_POSITION)
  ) u_axis_y (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl_y),
    .stop_neg   (stops_r[3]),
    .stop_pos   (stops_r[2]),
    .load_count (step_count_r),
    .load_period(period_r),
    .load_dir   (direction_r),
    .stat_nxt   (stat_y),
    .pos_nxt    (pos_y_nxt)
  );

  // Z has no end stops
  tasp_axis #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .POS_WIDTH    (POS_WIDTH),
    .HOME_POSITION(HOME_POSITION)
  ) u_axis_z (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl_z),
    .stop_neg   (1'b0),
    .stop_pos   (1'b0),
    .load_count (step_count_r),
    .load_period(period_r),
    .load_dir   (direction_r),
    .stat_nxt   (stat_z),
    .pos_nxt    (pos_z_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_x_r     <= stat_x;
      res_y_r     <= stat_y;
      res_z_r     <= stat_z;
      res_pos_x_r <= pos_x_nxt;
      res_pos_y_r <= pos_y_nxt;
      res_pos_z_r <= pos_z_nxt;
      res_taken_r <= stat_x.stepped || stat_y.stepped || stat_z.stepped;
      res_stops_r <= stop_status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_step_x      = res_x_r.step_level;
  assign out_step_y      = res_y_r.step_level;
  assign out_step_z      = res_z_r.step_level;
  assign out_dir_x       = res_x_r.dir_pin;
  assign out_dir_y       = res_y_r.dir_pin;
  assign out_dir_z       = res_z_r.dir_pin;
  assign out_pos_x       = res_pos_x_r;
  assign out_pos_y       = res_pos_y_r;
  assign out_pos_z       = res_pos_z_r;
  assign out_active_axes = {res_z_r.active, res_y_r.active, res_x_r.active};
  assign out_step_taken  = res_taken_r;
  assign out_stop_flags  = res_stops_r;

`ifndef SYNTH
  // A step is only ever reported together with a running axis
  a_taken_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_taken_r) |-> (out_active_axes != '0))
    else $error("step taken reported with no active axis");

  // Every processed item produces a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed item produced no result");

  // A reset transaction leaves everything idle and flags clear
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    is_clear |=> (out_active_axes == '0 && !res_taken_r && res_stops_r == '0))
    else $error("reset transaction result not idle");
`endif

endmodule

/* sv/tasp_axis.sv */
`timescale 1ns / 1ps

module tasp_axis import tasp_pkg::*; #(
  parameter int COUNT_WIDTH   = TASP_COUNT_WIDTH,
  parameter int POS_WIDTH     = TASP_POS_WIDTH,
  parameter int HOME_POSITION = TASP_HOME_POSITION
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  axis_ctrl_t                  ctrl,
  input  logic                        stop_neg,
  input  logic                        stop_pos,
  input  logic [COUNT_WIDTH-1:0]      load_count,
  input  logic [COUNT_WIDTH-1:0]      load_period,
  input  logic                        load_dir,
  output axis_stat_t                  stat_nxt,
  output logic signed [POS_WIDTH-1:0] pos_nxt
);

  localparam logic signed [POS_WIDTH-1:0] POS_MAX  = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] POS_MIN  = {1'b1, {(POS_WIDTH-1){1'b0}}};
  localparam logic signed [POS_WIDTH-1:0] POS_HOME = POS_WIDTH'(HOME_POSITION);
  localparam logic [POS_WIDTH-1:0]        POS_ONE  = POS_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0]      CNT_ONE  = COUNT_WIDTH'(1);

  logic                        active_r, active_nxt;
  logic                        move_dir_r, move_dir_nxt;
  logic [COUNT_WIDTH-1:0]      reload_r, reload_nxt;
  logic [COUNT_WIDTH-1:0]      period_left_r, period_left_nxt;
  logic [COUNT_WIDTH-1:0]      steps_left_r, steps_left_nxt;
  logic                        step_level_r, step_level_nxt;
  logic                        dir_pin_r, dir_pin_nxt;
  logic signed [POS_WIDTH-1:0] pos_r, pos_nxt_w;
  logic                        stepped;
  logic                        stop_hit;

  // End stop lying in the direction of travel
  assign stop_hit = (stop_neg && !move_dir_r) || (stop_pos && move_dir_r);

  // Next state for one transaction
  always_comb begin
    active_nxt      = active_r;
    move_dir_nxt    = move_dir_r;
    reload_nxt      = reload_r;
    period_left_nxt = period_left_r;
    steps_left_nxt  = steps_left_r;
    step_level_nxt  = step_level_r;
    dir_pin_nxt     = dir_pin_r;
    pos_nxt_w       = pos_r;
    stepped         = 1'b0;
    if (ctrl.clear) begin
      active_nxt      = 1'b0;
      move_dir_nxt    = 1'b0;
      reload_nxt      = '0;
      period_left_nxt = '0;
      steps_left_nxt  = '0;
      step_level_nxt  = 1'b0;
      dir_pin_nxt     = 1'b0;
      pos_nxt_w       = POS_HOME;
    end else if (ctrl.load) begin
      active_nxt      = 1'b1;
      steps_left_nxt  = load_count;
      reload_nxt      = load_period;
      period_left_nxt = '0;
      move_dir_nxt    = load_dir;
    end else if (ctrl.tick) begin
      if (stop_hit) begin
        active_nxt     = 1'b0;
        steps_left_nxt = '0;
      end
      // out of steps: stop before stepping
      if (active_nxt && (steps_left_nxt == '0)) begin
        active_nxt      = 1'b0;
        period_left_nxt = '0;
      end
      if (active_nxt) begin
        if (period_left_nxt == '0) begin
          step_level_nxt  = 1'b1;
          period_left_nxt = reload_r;
          steps_left_nxt  = steps_left_nxt - CNT_ONE;
          stepped         = 1'b1;
          if (move_dir_r) begin
            if (pos_r != POS_MAX) pos_nxt_w = pos_r + POS_ONE;
          end else begin
            if (pos_r != POS_MIN) pos_nxt_w = pos_r - POS_ONE;
          end
        end else begin
          if (step_level_r) begin
            step_level_nxt = 1'b0;
            dir_pin_nxt    = move_dir_r;
          end
          period_left_nxt = period_left_nxt - CNT_ONE;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      move_dir_r    <= 1'b0;
      reload_r      <= '0;
      period_left_r <= '0;
      steps_left_r  <= '0;
      step_level_r  <= 1'b0;
      dir_pin_r     <= 1'b0;
      pos_r         <= POS_HOME;
    end else begin
      active_r      <= active_nxt;
      move_dir_r    <= move_dir_nxt;
      reload_r      <= reload_nxt;
      period_left_r <= period_left_nxt;
      steps_left_r  <= steps_left_nxt;
      step_level_r  <= step_level_nxt;
      dir_pin_r     <= dir_pin_nxt;
      pos_r         <= pos_nxt_w;
    end
  end

  assign stat_nxt = '{step_level: step_level_nxt, dir_pin: dir_pin_nxt,
                      active: active_nxt, stepped: stepped};
  assign pos_nxt  = pos_nxt_w;

`ifndef SYNTH
  // A step leaves the step pin high and the axis still running
  a_step_raises_pin: assert property (@(posedge clk) disable iff (!rst_n)
    stepped |=> (step_level_r && active_r))
    else $error("step taken without step pin high and axis active");

  // A load arms the axis with its period counter cleared
  a_load_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.load && !ctrl.clear) |=> (active_r && (period_left_r == '0)))
    else $error("load did not arm the axis");

  // A reset transaction restores home and halts the axis
  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |=> ((pos_r == POS_HOME) && !active_r && !step_level_r))
    else $error("reset transaction did not restore axis state");
`endif

endmodule
